>>> rtl/dtti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to integer package
// Parse phases, status codes, character constants and small helper
// functions shared by the decimal text to integer converter.
// ----------------------------------------------------------------------------
package dtti_pkg;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_SKIP  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_SYNTAX    = 2'd3
    } status_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Largest magnitude that can still take a digit: floor((2^63 - 1) / 10).
    localparam logic [63:0] MAG_LIMIT_DIV = 64'd922337203685477580;
    localparam logic [3:0]  MAG_LIMIT_MOD = 4'd7;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // True when appending digit d would leave the signed 64-bit range.
    // A negative number may reach a magnitude one larger.
    function automatic logic digit_ovf(
        input logic [63:0] mag,
        input logic [3:0]  d,
        input logic        neg
    );
        logic [3:0] lim;
        lim = MAG_LIMIT_MOD + {3'b000, neg};
        digit_ovf = (mag > MAG_LIMIT_DIV) || ((mag == MAG_LIMIT_DIV) && (d > lim));
    endfunction

endpackage : dtti_pkg
`default_nettype wire

>>> rtl/decimal_text_to_integer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to integer core
// Parses a NUL-terminated decimal string, one character per item, into a
// signed 64-bit or range-checked 32-bit integer with a status code.
// ----------------------------------------------------------------------------
// Usage:
// Characters enter on the in_valid / in_ready channel, one item per cycle
// while in_ready is high. The accepted string has the form spaces, optional
// sign, spaces, digits, spaces (no digits give zero); a NUL character closes
// it. Only the NUL produces an item on the out_valid / out_ready channel,
// carrying value and status (0 ok, 1 overflow, 2 underflow, 3 syntax error).
// value is zero unless status is ok. An accepted character is registered in
// the input stage and processed by the parse logic; for a NUL the result
// goes into the output register.
// Throughput is one character per cycle while in_ready is high, limited by
// the combinational magnitude update (multiply by ten, add, limit compare).
// When the receiver stalls, the result waits in the output register; the
// input stage keeps taking non-NUL characters, and a NUL waits in the input
// stage until the output register is free, which then holds off in_ready.
// Reset clears the parse state, the output valid and narrow_mode (64-bit mode).
// The user writes narrow_mode (cfg_we, cfg_wdata) only while idle; not enforced.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_core
    import dtti_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         ch,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [63:0]      value,
    output logic [1:0]              status
);

    // Input stage.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  ch_reg;

    // Parse state.
    phase_t      phase_reg;
    phase_t      phase_next;
    logic        neg_reg;
    logic        neg_next;
    logic [63:0] mag_reg;
    logic [63:0] mag_next;
    status_t     err_reg;
    status_t     err_next;

    // Configuration.
    logic        narrow_mode_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] value_reg;
    logic [63:0] value_next;
    status_t     status_reg;
    status_t     status_next;

    logic        is_nul;
    logic        advance;

    assign is_nul = (ch_reg == CH_NUL);

    // The input stage moves on whenever it holds a character; a NUL also
    // needs the output register to be free or draining this cycle.
    assign advance  = in_valid_reg && (!is_nul || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
    end

    // Parse step and result formation.
    always_comb
    begin
        logic [3:0]  d;
        logic [63:0] mag10;
        logic [63:0] v;
        logic        bad;

        d     = ch_reg[3:0] - CH_ZERO[3:0];
        mag10 = (mag_reg << 3) + (mag_reg << 1) + {60'd0, d};
        v     = neg_reg ? (64'd0 - mag_reg) : mag_reg;
        // A 32-bit value needs bits 63..31 all equal.
        bad   = !((&v[63:31]) || !(|v[63:31]));

        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        status_next    = status_reg;

        if (advance)
        begin
            if (is_nul)
            begin
                out_valid_next = 1'b1;
                if (err_reg != ST_OK)
                begin
                    value_next  = 64'd0;
                    status_next = err_reg;
                end
                else if (narrow_mode_reg && bad)
                begin
                    value_next  = 64'd0;
                    status_next = v[63] ? ST_UNDERFLOW : ST_OVERFLOW;
                end
                else
                begin
                    value_next  = v;
                    status_next = ST_OK;
                end
                phase_next = PH_LEAD;
                neg_next   = 1'b0;
                mag_next   = 64'd0;
                err_next   = ST_OK;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD, PH_SIGN, PH_DIGIT:
                    begin
                        if (is_dig(ch_reg))
                        begin
                            if (digit_ovf(mag_reg, d, neg_reg))
                            begin
                                err_next   = neg_reg ? ST_UNDERFLOW : ST_OVERFLOW;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                mag_next   = mag10;
                                phase_next = PH_DIGIT;
                            end
                        end
                        else if (is_ws(ch_reg))
                        begin
                            if (phase_reg == PH_DIGIT)
                            begin
                                phase_next = PH_TRAIL;
                            end
                        end
                        else if ((phase_reg == PH_LEAD) && (ch_reg == CH_MINUS))
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_SIGN;
                        end
                        else if ((phase_reg == PH_LEAD) && (ch_reg == CH_PLUS))
                        begin
                            phase_next = PH_SIGN;
                        end
                        else
                        begin
                            err_next   = ST_SYNTAX;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_TRAIL:
                    begin
                        if (!is_ws(ch_reg))
                        begin
                            err_next   = ST_SYNTAX;
                            phase_next = PH_SKIP;
                        end
                    end
                    default:
                    begin
                        // Skip phase and unused codes wait for the NUL.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_LEAD;
            neg_reg         <= 1'b0;
            mag_reg         <= 64'd0;
            err_reg         <= ST_OK;
            narrow_mode_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                narrow_mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ch_reg <= ch;
        end
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule : decimal_text_to_integer_core
`default_nettype wire
